FILE: rtl/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared constants, codes and types of the one-wire bus master.
// ----------------------------------------------------------------------------
package owbm_pkg;

    localparam int DEFAULT_TIMER_BITS = 10;

    localparam int CFG_W       = 10;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_COUNT   = 7;

    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_LOW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_HOLD    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_READ_TAIL     = 3'd6;

    localparam logic [CFG_W-1:0] RST_RESET_LOW     = 10'd480;
    localparam logic [CFG_W-1:0] RST_PRESENCE_WAIT = 10'd60;
    localparam logic [CFG_W-1:0] RST_RESET_TAIL    = 10'd420;
    localparam logic [CFG_W-1:0] RST_SLOT_LOW      = 10'd1;
    localparam logic [CFG_W-1:0] RST_WRITE_HOLD    = 10'd60;
    localparam logic [CFG_W-1:0] RST_READ_SAMPLE   = 10'd14;
    localparam logic [CFG_W-1:0] RST_READ_TAIL     = 10'd45;

    localparam logic [1:0] OP_RESET      = 2'd0;
    localparam logic [1:0] OP_WRITE_BYTE = 2'd1;
    localparam logic [1:0] OP_READ_BYTE  = 2'd2;
    localparam logic [1:0] OP_READ_BIT   = 2'd3;

    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 16;

    typedef struct packed {
        logic [CFG_W-1:0] reset_low;
        logic [CFG_W-1:0] presence_wait;
        logic [CFG_W-1:0] reset_tail;
        logic [CFG_W-1:0] slot_low;
        logic [CFG_W-1:0] write_hold;
        logic [CFG_W-1:0] read_sample;
        logic [CFG_W-1:0] read_tail;
    } timing_cfg_t;

endpackage

FILE: rtl/owbm_cfg_regs.sv
// ----------------------------------------------------------------------------
// owbm_cfg_regs
// Bus timing register file: decodes indexed writes, holds reset defaults.
// ----------------------------------------------------------------------------
module owbm_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [owbm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [owbm_pkg::CFG_W-1:0]          cfg_data,
    output owbm_pkg::timing_cfg_t               timing
);

    owbm_pkg::timing_cfg_t timing_reg;

    assign cfg_ready = 1'b1;
    assign timing    = timing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.reset_low     <= owbm_pkg::RST_RESET_LOW;
            timing_reg.presence_wait <= owbm_pkg::RST_PRESENCE_WAIT;
            timing_reg.reset_tail    <= owbm_pkg::RST_RESET_TAIL;
            timing_reg.slot_low      <= owbm_pkg::RST_SLOT_LOW;
            timing_reg.write_hold    <= owbm_pkg::RST_WRITE_HOLD;
            timing_reg.read_sample   <= owbm_pkg::RST_READ_SAMPLE;
            timing_reg.read_tail     <= owbm_pkg::RST_READ_TAIL;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                owbm_pkg::REG_RESET_LOW:     timing_reg.reset_low     <= cfg_data;
                owbm_pkg::REG_PRESENCE_WAIT: timing_reg.presence_wait <= cfg_data;
                owbm_pkg::REG_RESET_TAIL:    timing_reg.reset_tail    <= cfg_data;
                owbm_pkg::REG_SLOT_LOW:      timing_reg.slot_low      <= cfg_data;
                owbm_pkg::REG_WRITE_HOLD:    timing_reg.write_hold    <= cfg_data;
                owbm_pkg::REG_READ_SAMPLE:   timing_reg.read_sample   <= cfg_data;
                owbm_pkg::REG_READ_TAIL:     timing_reg.read_tail     <= cfg_data;
                default:                     ;
            endcase
        end
    end

endmodule

FILE: rtl/one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master
// One-wire bus master stepped by one input transfer per microsecond tick.
// ----------------------------------------------------------------------------
// An input transfer's result is registered, valid in the cycle after it.
// Throughput: one tick per clock cycle while m_axis_tready is high; the
//   result register and timer update in the same cycle, so both streams run.
// Reset: asynchronous, active low; phase idle, counters and shifter zero,
//   presence level one, timing registers at their default values.
// ----------------------------------------------------------------------------
module one_wire_bus_master #(
    parameter int TIMER_BITS = owbm_pkg::DEFAULT_TIMER_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] write_data, [8] line_level, [15:9] zero
    input  logic [owbm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [0] start_req, [2:1] opcode
    input  logic [owbm_pkg::IN_USER_W-1:0]      s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] drive_low, [1] busy_res, [9:2] read_data, [10] presence_level,
    // [15:11] zero
    output logic [owbm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // done_res
    output logic                                m_axis_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [owbm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [owbm_pkg::CFG_W-1:0]          cfg_data
);

    localparam int CW = (TIMER_BITS > owbm_pkg::CFG_W) ? TIMER_BITS : owbm_pkg::CFG_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_REL,
        PH_RST_TAIL,
        PH_SLOT_LOW,
        PH_SLOT_HOLD,
        PH_SLOT_WAIT,
        PH_SLOT_TAIL
    } phase_t;

    function automatic logic [TIMER_BITS-1:0] clamp_ticks(input logic [CW-1:0] v);
        clamp_ticks = (v > CW'(TIMER_MAX)) ? TIMER_MAX : v[TIMER_BITS-1:0];
    endfunction

    function automatic logic [TIMER_BITS-1:0] last_of(input logic [owbm_pkg::CFG_W-1:0] d);
        logic [owbm_pkg::CFG_W-1:0] v;
        v = (d == '0) ? '0 : d - 1'b1;
        last_of = clamp_ticks(CW'(v));
    endfunction

    function automatic logic [TIMER_BITS-1:0] tail_last(input logic [owbm_pkg::CFG_W-1:0] t);
        tail_last = clamp_ticks(CW'(t));
    endfunction

    owbm_pkg::timing_cfg_t timing;

    owbm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .timing    (timing)
    );

    phase_t                             phase_reg, phase_next;
    logic [TIMER_BITS-1:0]              timer_reg, timer_next;
    logic [3:0]                         bits_left_reg, bits_left_next;
    logic [7:0]                         shift_reg, shift_next;
    logic [1:0]                         active_op_reg, active_op_next;
    logic                               presence_reg, presence_next;
    logic                               m_tvalid_reg;
    logic [owbm_pkg::OUT_DATA_W-1:0]    m_tdata_reg, m_tdata_next;
    logic                               m_tlast_reg;

    logic                               start_req;
    logic [1:0]                         opcode;
    logic [7:0]                         write_data;
    logic                               line_level;
    logic                               in_xfer;

    phase_t                             ph;
    logic [TIMER_BITS-1:0]              tmr;
    logic [3:0]                         bl;
    logic [7:0]                         sh;
    logic [3:0]                         bl_dec;
    logic                               ends;
    logic                               drive_low, busy_res, done_res;
    logic [7:0]                         read_data;

    assign start_req  = s_axis_tuser[0];
    assign opcode     = s_axis_tuser[2:1];
    assign write_data = s_axis_tdata[7:0];
    assign line_level = s_axis_tdata[8];

    assign s_axis_tready = !m_tvalid_reg || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tlast  = m_tlast_reg;

    always_comb
    begin
        ph             = phase_reg;
        tmr            = timer_reg;
        bl             = bits_left_reg;
        sh             = shift_reg;
        active_op_next = active_op_reg;
        presence_next  = presence_reg;
        drive_low      = 1'b0;
        busy_res       = 1'b0;
        done_res       = 1'b0;
        read_data      = '0;
        ends           = 1'b0;

        if (phase_reg == PH_IDLE && start_req)
        begin
            active_op_next = opcode;
            sh  = (opcode == owbm_pkg::OP_WRITE_BYTE) ? write_data : 8'd0;
            bl  = (opcode == owbm_pkg::OP_READ_BIT) ? 4'd1 :
                  (opcode == owbm_pkg::OP_RESET)    ? 4'd0 : 4'd8;
            ph  = (opcode == owbm_pkg::OP_RESET) ? PH_RST_LOW : PH_SLOT_LOW;
            tmr = '0;
        end

        bl_dec         = bl - 4'd1;
        phase_next     = ph;
        timer_next     = tmr;
        bits_left_next = bl;
        shift_next     = sh;

        if (ph != PH_IDLE)
        begin
            busy_res = 1'b1;
            case (ph)
                PH_RST_LOW:
                begin
                    drive_low = 1'b1;
                    if (tmr == last_of(timing.reset_low))
                    begin
                        phase_next = PH_RST_REL;
                        ends       = 1'b1;
                    end
                end
                PH_RST_REL:
                begin
                    if (tmr == last_of(timing.presence_wait))
                    begin
                        phase_next = PH_RST_TAIL;
                        ends       = 1'b1;
                    end
                end
                PH_RST_TAIL:
                begin
                    if (tmr == '0)
                    begin
                        presence_next = line_level;
                    end
                    if (tmr == tail_last(timing.reset_tail))
                    begin
                        done_res   = 1'b1;
                        phase_next = PH_IDLE;
                        ends       = 1'b1;
                    end
                end
                PH_SLOT_LOW:
                begin
                    drive_low = 1'b1;
                    if (tmr == last_of(timing.slot_low))
                    begin
                        phase_next = (active_op_next == owbm_pkg::OP_WRITE_BYTE) ?
                                     PH_SLOT_HOLD : PH_SLOT_WAIT;
                        ends       = 1'b1;
                    end
                end
                PH_SLOT_HOLD:
                begin
                    drive_low = !sh[0];
                    if (tmr == last_of(timing.write_hold))
                    begin
                        shift_next     = {1'b0, sh[7:1]};
                        bits_left_next = bl_dec;
                        if (bl_dec == 4'd0)
                        begin
                            done_res   = 1'b1;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_SLOT_LOW;
                        end
                        ends = 1'b1;
                    end
                end
                PH_SLOT_WAIT:
                begin
                    if (tmr == last_of(timing.read_sample))
                    begin
                        phase_next = PH_SLOT_TAIL;
                        ends       = 1'b1;
                    end
                end
                PH_SLOT_TAIL:
                begin
                    if (tmr == '0)
                    begin
                        shift_next = {line_level, sh[7:1]};
                    end
                    if (tmr == tail_last(timing.read_tail))
                    begin
                        bits_left_next = bl_dec;
                        if (bl_dec == 4'd0)
                        begin
                            done_res   = 1'b1;
                            read_data  = (active_op_next == owbm_pkg::OP_READ_BIT) ?
                                         {7'd0, shift_next[7]} : shift_next;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_SLOT_LOW;
                        end
                        ends = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    ends       = 1'b1;
                end
            endcase
            timer_next = ends ? '0 : tmr + 1'b1;
        end

        m_tdata_next = {5'd0, presence_next, read_data, busy_res, drive_low};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            timer_reg     <= '0;
            bits_left_reg <= '0;
            shift_reg     <= '0;
            active_op_reg <= '0;
            presence_reg  <= 1'b1;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
            m_tlast_reg   <= 1'b0;
        end
        else if (in_xfer)
        begin
            phase_reg     <= phase_next;
            timer_reg     <= timer_next;
            bits_left_reg <= bits_left_next;
            shift_reg     <= shift_next;
            active_op_reg <= active_op_next;
            presence_reg  <= presence_next;
            m_tvalid_reg  <= 1'b1;
            m_tdata_reg   <= m_tdata_next;
            m_tlast_reg   <= done_res;
        end
        else if (m_axis_tready)
        begin
            m_tvalid_reg  <= 1'b0;
        end
    end

endmodule

FILE: sim/tb_one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// tb_one_wire_bus_master
// Self-checking bench for the one-wire bus master. A table of bus ticks comes
// first, with expected results typed in for the obvious rows. Random ticks
// follow under short random timing settings. Every tick without a typed
// result is scored against a cycle-true model of the bus phases kept in the
// bench. Both stream sides stall in random bursts. Once, the result side holds
// off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_one_wire_bus_master;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES  = 9;
    localparam int LONG_HOLD     = 48;
    localparam int SETTLE_CYCLES = 4;
    localparam int WATCHDOG      = 1000;
    localparam int SCRIPT_ROWS   = 16;

    localparam logic [owbm_pkg::CFG_W-1:0] RESET_TIMING [owbm_pkg::CFG_COUNT] = '{
        owbm_pkg::RST_RESET_LOW, owbm_pkg::RST_PRESENCE_WAIT, owbm_pkg::RST_RESET_TAIL,
        owbm_pkg::RST_SLOT_LOW, owbm_pkg::RST_WRITE_HOLD, owbm_pkg::RST_READ_SAMPLE,
        owbm_pkg::RST_READ_TAIL
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RESET_LOW,
        ST_RESET_RELEASE,
        ST_PRESENCE_TAIL,
        ST_SLOT_LOW,
        ST_WRITE_HOLD,
        ST_READ_WAIT,
        ST_READ_TAIL
    } bus_state_t;

    typedef enum {
        TIMING_DEFAULT,
        TIMING_ZERO,
        TIMING_SMALL,
        TIMING_MAX,
        TIMING_MIXED
    } timing_mode_t;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
        logic [7:0] wdata;
        logic       line;
    } bus_tick_t;

    typedef struct packed {
        logic       drive;
        logic       busy;
        logic       done;
        logic [7:0] rdata;
        logic       presence;
    } bus_obs_t;

    typedef struct packed {
        bus_tick_t  tk;
        logic [5:0] reps;
        logic       typed;
        bus_obs_t   want;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [owbm_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
    logic [owbm_pkg::IN_USER_W-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [owbm_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic m_axis_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [owbm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [owbm_pkg::CFG_W-1:0] cfg_data = '0;

    // bus model state
    bus_state_t bus_st = ST_IDLE;
    logic [owbm_pkg::DEFAULT_TIMER_BITS-1:0] elapsed = '0;
    logic [3:0] bits_left = '0;
    logic [7:0] shifter = '0;
    logic [1:0] cur_op = owbm_pkg::OP_RESET;
    logic presence = 1'b1;
    logic [owbm_pkg::CFG_W-1:0] timing [owbm_pkg::CFG_COUNT] = RESET_TIMING;

    bus_obs_t expected_q [$];
    script_row_t script [SCRIPT_ROWS];

    logic gaps_on = 1'b0;
    logic hold_request = 1'b0;
    int errors = 0;
    int ticks_sent = 0;
    int settings_run = 0;
    int idle_cycles = 0;
    int done_count [4] = '{0, 0, 0, 0};

    one_wire_bus_master dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic logic [owbm_pkg::CFG_W-1:0] last_tick(
        input logic [owbm_pkg::CFG_W-1:0] d);
        return (d == '0) ? '0 : d - 1'b1;
    endfunction

    function automatic script_row_t dir_row(input logic start, input logic [1:0] op,
                                            input logic [7:0] wdata, input logic line,
                                            input int reps, input logic typed,
                                            input bus_obs_t want);
        script_row_t r;
        r.tk = '{start: start, op: op, wdata: wdata, line: line};
        r.reps = reps[5:0];
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    function automatic bus_obs_t advance_bus(input bus_tick_t tk);
        bus_obs_t o;
        logic hit;
        bus_state_t nxt;
        o = '0;
        hit = 1'b0;
        nxt = ST_IDLE;
        if (bus_st == ST_IDLE && tk.start)
        begin
            cur_op = tk.op;
            shifter = (tk.op == owbm_pkg::OP_WRITE_BYTE) ? tk.wdata : 8'h00;
            case (tk.op)
                owbm_pkg::OP_RESET:    bits_left = 4'd0;
                owbm_pkg::OP_READ_BIT: bits_left = 4'd1;
                default:               bits_left = 4'd8;
            endcase
            bus_st = (tk.op == owbm_pkg::OP_RESET) ? ST_RESET_LOW : ST_SLOT_LOW;
            elapsed = '0;
        end
        if (bus_st != ST_IDLE)
        begin
            o.busy = 1'b1;
            case (bus_st)
                ST_RESET_LOW:
                begin
                    o.drive = 1'b1;
                    hit = elapsed == last_tick(timing[owbm_pkg::REG_RESET_LOW]);
                    nxt = ST_RESET_RELEASE;
                end
                ST_RESET_RELEASE:
                begin
                    hit = elapsed == last_tick(timing[owbm_pkg::REG_PRESENCE_WAIT]);
                    nxt = ST_PRESENCE_TAIL;
                end
                ST_PRESENCE_TAIL:
                begin
                    if (elapsed == '0)
                        presence = tk.line;
                    hit = elapsed == timing[owbm_pkg::REG_RESET_TAIL];
                    o.done = hit;
                    nxt = ST_IDLE;
                end
                ST_SLOT_LOW:
                begin
                    o.drive = 1'b1;
                    hit = elapsed == last_tick(timing[owbm_pkg::REG_SLOT_LOW]);
                    nxt = (cur_op == owbm_pkg::OP_WRITE_BYTE) ? ST_WRITE_HOLD : ST_READ_WAIT;
                end
                ST_WRITE_HOLD:
                begin
                    o.drive = ~shifter[0];
                    hit = elapsed == last_tick(timing[owbm_pkg::REG_WRITE_HOLD]);
                    if (hit)
                    begin
                        shifter = shifter >> 1;
                        bits_left = bits_left - 4'd1;
                    end
                    o.done = hit && bits_left == 4'd0;
                    nxt = o.done ? ST_IDLE : ST_SLOT_LOW;
                end
                ST_READ_WAIT:
                begin
                    hit = elapsed == last_tick(timing[owbm_pkg::REG_READ_SAMPLE]);
                    nxt = ST_READ_TAIL;
                end
                ST_READ_TAIL:
                begin
                    if (elapsed == '0)
                        shifter = {tk.line, shifter[7:1]};
                    hit = elapsed == timing[owbm_pkg::REG_READ_TAIL];
                    if (hit)
                        bits_left = bits_left - 4'd1;
                    o.done = hit && bits_left == 4'd0;
                    if (o.done)
                        o.rdata = (cur_op == owbm_pkg::OP_READ_BIT) ?
                                  {7'd0, shifter[7]} : shifter;
                    nxt = o.done ? ST_IDLE : ST_SLOT_LOW;
                end
                default:
                begin
                    hit = 1'b1;
                    nxt = ST_IDLE;
                end
            endcase
            if (hit)
            begin
                bus_st = nxt;
                elapsed = '0;
            end
            else
                elapsed = elapsed + 1'b1;
            if (o.done)
                done_count[cur_op]++;
        end
        o.presence = presence;
        return o;
    endfunction

    function automatic bus_tick_t random_tick(input logic may_start);
        bus_tick_t tk;
        if (!may_start)
            tk.start = 1'b0;
        else if (bus_st == ST_IDLE)
            tk.start = $urandom_range(0, 2) != 0;
        else
            tk.start = 1'($urandom_range(0, 1));
        tk.op = 2'($urandom_range(0, 3));
        tk.wdata = 8'($urandom_range(0, 255));
        tk.line = 1'($urandom_range(0, 1));
        return tk;
    endfunction

    task automatic send_tick(input bus_tick_t tk, input logic use_want, input bus_obs_t want);
        bus_obs_t predicted;
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, tk.line, tk.wdata};
        s_axis_tuser <= {tk.op, tk.start};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = advance_bus(tk);
        expected_q.push_back(use_want ? want : predicted);
        ticks_sent++;
    endtask

    task automatic load_timing(input timing_mode_t mode);
        logic [owbm_pkg::CFG_W-1:0] v;
        cfg_valid <= 1'b1;
        for (int i = 0; i < owbm_pkg::CFG_COUNT; i++)
        begin
            case (mode)
                TIMING_DEFAULT: v = RESET_TIMING[i];
                TIMING_ZERO:    v = '0;
                TIMING_SMALL:   v = owbm_pkg::CFG_W'($urandom_range(0, 3));
                TIMING_MAX:     v = '1;
                default:        v = ($urandom_range(0, 3) == 0) ?
                                    owbm_pkg::CFG_W'($urandom_range(6, 15)) :
                                    owbm_pkg::CFG_W'($urandom_range(0, 5));
            endcase
            cfg_index <= owbm_pkg::CFG_IDX_W'(i);
            cfg_data <= v;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            timing[i] = v;
        end
        cfg_valid <= 1'b0;
        settings_run++;
    endtask

    // finish the command in flight, then drain all results
    task automatic settle();
        while (bus_st != ST_IDLE)
            send_tick(random_tick(1'b0), 1'b0, '0);
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input timing_mode_t mode, input int n, input logic gaps,
                             input logic squeeze);
        load_timing(mode);
        gaps_on = gaps;
        hold_request = squeeze;
        repeat (n) send_tick(random_tick(1'b1), 1'b0, '0);
        settle();
    endtask

    task automatic note_mismatch(input string field, input int want, input int got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        errors++;
    endtask

    initial
    begin : result_sink
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        bus_obs_t got;
        bus_obs_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.drive = m_axis_tdata[0];
            got.busy = m_axis_tdata[1];
            got.done = m_axis_tlast;
            got.rdata = m_axis_tdata[9:2];
            got.presence = m_axis_tdata[10];
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result transfer, actual 0x%03h", $time,
                         m_axis_tdata[10:0]);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.drive !== want.drive)
                    note_mismatch("drive_low", want.drive, got.drive);
                if (got.busy !== want.busy)
                    note_mismatch("busy_res", want.busy, got.busy);
                if (got.done !== want.done)
                    note_mismatch("done_res", want.done, got.done);
                if (got.rdata !== want.rdata)
                    note_mismatch("read_data", want.rdata, got.rdata);
                if (got.presence !== want.presence)
                    note_mismatch("presence_level", want.presence, got.presence);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin : stimulus
        // timing all zero: each phase one tick, tails end on their sample tick
        script = '{
            dir_row(1'b0, owbm_pkg::OP_RESET,      8'h00, 1'b1,  1, 1'b1,
                    {1'b0, 1'b0, 1'b0, 8'h00, 1'b1}),
            dir_row(1'b1, owbm_pkg::OP_RESET,      8'hFF, 1'b1,  1, 1'b1,
                    {1'b1, 1'b1, 1'b0, 8'h00, 1'b1}),
            dir_row(1'b1, owbm_pkg::OP_READ_BIT,   8'h00, 1'b0,  1, 1'b1,
                    {1'b0, 1'b1, 1'b0, 8'h00, 1'b1}),
            dir_row(1'b0, owbm_pkg::OP_RESET,      8'h00, 1'b0,  1, 1'b1,
                    {1'b0, 1'b1, 1'b1, 8'h00, 1'b0}),
            dir_row(1'b1, owbm_pkg::OP_READ_BIT,   8'h55, 1'b1,  1, 1'b1,
                    {1'b1, 1'b1, 1'b0, 8'h00, 1'b0}),
            dir_row(1'b0, owbm_pkg::OP_READ_BIT,   8'h00, 1'b1,  1, 1'b1,
                    {1'b0, 1'b1, 1'b0, 8'h00, 1'b0}),
            dir_row(1'b0, owbm_pkg::OP_READ_BIT,   8'h00, 1'b1,  1, 1'b1,
                    {1'b0, 1'b1, 1'b1, 8'h01, 1'b0}),
            dir_row(1'b1, owbm_pkg::OP_RESET,      8'h00, 1'b1,  3, 1'b0, '0),
            dir_row(1'b1, owbm_pkg::OP_WRITE_BYTE, 8'hFF, 1'b0,  1, 1'b1,
                    {1'b1, 1'b1, 1'b0, 8'h00, 1'b1}),
            dir_row(1'b0, owbm_pkg::OP_WRITE_BYTE, 8'h00, 1'b0,  1, 1'b1,
                    {1'b0, 1'b1, 1'b0, 8'h00, 1'b1}),
            dir_row(1'b1, owbm_pkg::OP_RESET,      8'h00, 1'b1, 14, 1'b0, '0),
            dir_row(1'b1, owbm_pkg::OP_WRITE_BYTE, 8'h00, 1'b1, 16, 1'b0, '0),
            dir_row(1'b1, owbm_pkg::OP_READ_BYTE,  8'h00, 1'b1, 24, 1'b0, '0),
            dir_row(1'b1, owbm_pkg::OP_READ_BYTE,  8'hFF, 1'b0, 24, 1'b0, '0),
            dir_row(1'b1, owbm_pkg::OP_READ_BIT,   8'h00, 1'b0,  3, 1'b0, '0),
            dir_row(1'b0, owbm_pkg::OP_RESET,      8'h00, 1'b0,  2, 1'b0, '0)
        };
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_timing(TIMING_ZERO);
        gaps_on = 1'b1;
        foreach (script[r])
            for (int k = 0; k < script[r].reps; k++)
                send_tick(script[r].tk, script[r].typed && script[r].reps == 1,
                          script[r].want);
        settle();

        run_phase(TIMING_SMALL,   90, 1'b1, 1'b1);
        run_phase(TIMING_MIXED,   60, 1'b1, 1'b0);
        run_phase(TIMING_SMALL,   80, 1'b0, 1'b0);

        $display("Sent %0d bus ticks under %0d timing settings, all zero and short random,",
                 ticks_sent, settings_run);
        $display("finishing %0d resets, %0d byte writes, %0d byte reads, %0d bit reads.",
                 done_count[owbm_pkg::OP_RESET], done_count[owbm_pkg::OP_WRITE_BYTE],
                 done_count[owbm_pkg::OP_READ_BYTE], done_count[owbm_pkg::OP_READ_BIT]);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: files.f
rtl/owbm_pkg.sv
rtl/owbm_cfg_regs.sv
rtl/one_wire_bus_master.sv
sim/tb_one_wire_bus_master.sv
